// ===== rtl/mbet_pkg.sv =====
package mbet_pkg;

  localparam int unsigned MAX_DIM_DEF     = 8192;
  localparam int unsigned COORD_WIDTH_DEF = 32;
  localparam int unsigned FRAC_BITS_DEF   = 24;

  localparam int unsigned ITER_W   = 8;
  localparam int unsigned STEP_W   = 25;
  localparam int unsigned ORIGIN_W = 32;
  localparam int unsigned PIXEL_W  = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_STEP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_X_ORIGIN   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Y_ORIGIN   = 2'd3;

  localparam logic [ITER_W-1:0]          MAX_ITER_RST   = 8'd255;
  localparam logic [STEP_W-1:0]          PIXEL_STEP_RST = 25'd10066;
  localparam logic signed [ORIGIN_W-1:0] X_ORIGIN_RST   = -32'sd33554432;
  localparam logic signed [ORIGIN_W-1:0] Y_ORIGIN_RST   = -32'sd25165824;
  localparam logic [PIXEL_W-1:0]         LEVEL_TOP      = 8'd255;

  typedef struct packed {
    logic [ITER_W-1:0]          max_iter;
    logic [STEP_W-1:0]          pixel_step;
    logic signed [ORIGIN_W-1:0] x_origin;
    logic signed [ORIGIN_W-1:0] y_origin;
  } cfg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COORD,
    ST_MUL,
    ST_STEP
  } state_e;

  typedef struct packed {
    logic load;
    logic coord;
    logic mul;
    logic step;
  } cmd_t;

  typedef struct packed {
    logic finish;
  } status_t;

endpackage

// ===== rtl/mbet_cfg.sv =====
module mbet_cfg (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [mbet_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [mbet_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  output mbet_pkg::cfg_t                       cfg_o
);
  import mbet_pkg::*;

  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_iter   <= MAX_ITER_RST;
      cfg_q.pixel_step <= PIXEL_STEP_RST;
      cfg_q.x_origin   <= X_ORIGIN_RST;
      cfg_q.y_origin   <= Y_ORIGIN_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_MAX_ITER:   cfg_q.max_iter   <= cfg_data_i[ITER_W-1:0];
        REG_PIXEL_STEP: cfg_q.pixel_step <= cfg_data_i[STEP_W-1:0];
        REG_X_ORIGIN:   cfg_q.x_origin   <= cfg_data_i[ORIGIN_W-1:0];
        REG_Y_ORIGIN:   cfg_q.y_origin   <= cfg_data_i[ORIGIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== rtl/mbet_ctrl.sv =====
module mbet_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  output mbet_pkg::cmd_t      cmd_o,
  input  mbet_pkg::status_t   status_i
);
  import mbet_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (start_i) state_d = ST_COORD;
      ST_COORD: state_d = ST_MUL;
      ST_MUL:   state_d = ST_STEP;
      ST_STEP:  state_d = status_i.finish ? ST_IDLE : ST_MUL;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        busy_o     = 1'b0;
        cmd_o.load = start_i;
      end
      ST_COORD: cmd_o.coord = 1'b1;
      ST_MUL:   cmd_o.mul   = 1'b1;
      ST_STEP:  cmd_o.step  = 1'b1;
      default:  busy_o      = 1'b0;
    endcase
  end

endmodule

// ===== rtl/mbet_dp.sv =====
module mbet_dp #(
  parameter int unsigned MAX_DIM     = mbet_pkg::MAX_DIM_DEF,
  parameter int unsigned COORD_WIDTH = mbet_pkg::COORD_WIDTH_DEF,
  parameter int unsigned FRAC_BITS   = mbet_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  mbet_pkg::cmd_t                 cmd_i,
  input  mbet_pkg::cfg_t                 cfg_i,
  input  logic [$clog2(MAX_DIM)-1:0]     x_index_i,
  input  logic [$clog2(MAX_DIM)-1:0]     y_index_i,
  output mbet_pkg::status_t              status_o,
  output logic [mbet_pkg::PIXEL_W-1:0]   pixel_value_o,
  output logic                           done_o
);
  import mbet_pkg::*;

  localparam int unsigned IW  = $clog2(MAX_DIM);
  localparam int unsigned MW  = IW + STEP_W;
  localparam int unsigned SW0 = (MW > ORIGIN_W) ? MW : ORIGIN_W;
  localparam int unsigned SW  = ((SW0 > COORD_WIDTH) ? SW0 : COORD_WIDTH) + 2;
  localparam int unsigned ZW  = FRAC_BITS + 3;
  localparam int unsigned PW  = 2 * ZW;
  localparam int unsigned DW  = PW + 1 - FRAC_BITS;
  localparam int unsigned AW  = ((DW > COORD_WIDTH) ? DW : COORD_WIDTH) + 1;

  localparam logic [IW-1:0] LAST_IDX = IW'(MAX_DIM - 1);
  localparam logic signed [SW-1:0] C_MAX =
    {{(SW-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [SW-1:0] C_MIN = ~C_MAX;
  localparam logic signed [AW-1:0] A_MAX =
    {{(AW-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [AW-1:0] A_MIN    = ~A_MAX;
  localparam logic signed [AW-1:0] FOUR     = AW'(4) << FRAC_BITS;
  localparam logic signed [AW-1:0] NEG_FOUR = -FOUR;
  localparam logic [PW:0]          LIMIT    = (PW+1)'(1) << (2 * FRAC_BITS + 4);

  logic [IW-1:0]                   xi_c, yi_c;
  logic [MW-1:0]                   px_q, py_q;
  logic signed [SW-1:0]            sx, sy;
  logic signed [COORD_WIDTH-1:0]   cr_d, ci_d, cr_q, ci_q;
  logic signed [ZW-1:0]            zr_q, zi_q;
  logic signed [PW-1:0]            rr_q, ii_q, ri_q;
  logic signed [PW:0]              diff, dbl;
  logic signed [AW-1:0]            nr_a, ni_a, nr_s, ni_s;
  logic [PW:0]                     mag;
  logic                            pass, more, rng_ok, go_on;
  logic [ITER_W-1:0]               cnt_q;
  logic                            pend_q, done_q;
  logic [PIXEL_W-1:0]              level_q;

  assign xi_c = (x_index_i > LAST_IDX) ? LAST_IDX : x_index_i;
  assign yi_c = (y_index_i > LAST_IDX) ? LAST_IDX : y_index_i;

  assign sx = $signed({{(SW-ORIGIN_W){cfg_i.x_origin[ORIGIN_W-1]}}, cfg_i.x_origin})
            + $signed({{(SW-MW){1'b0}}, px_q});
  assign sy = $signed({{(SW-ORIGIN_W){cfg_i.y_origin[ORIGIN_W-1]}}, cfg_i.y_origin})
            + $signed({{(SW-MW){1'b0}}, py_q});

  always_comb begin
    if (sx > C_MAX)      cr_d = C_MAX[COORD_WIDTH-1:0];
    else if (sx < C_MIN) cr_d = C_MIN[COORD_WIDTH-1:0];
    else                 cr_d = sx[COORD_WIDTH-1:0];
    if (sy > C_MAX)      ci_d = C_MAX[COORD_WIDTH-1:0];
    else if (sy < C_MIN) ci_d = C_MIN[COORD_WIDTH-1:0];
    else                 ci_d = sy[COORD_WIDTH-1:0];
  end

  assign diff = $signed({rr_q[PW-1], rr_q}) - $signed({ii_q[PW-1], ii_q});
  assign dbl  = $signed({ri_q, 1'b0});

  assign nr_a = $signed({{(AW-DW){diff[PW]}}, diff[PW:FRAC_BITS]})
              + $signed({{(AW-COORD_WIDTH){cr_q[COORD_WIDTH-1]}}, cr_q});
  assign ni_a = $signed({{(AW-DW){dbl[PW]}}, dbl[PW:FRAC_BITS]})
              + $signed({{(AW-COORD_WIDTH){ci_q[COORD_WIDTH-1]}}, ci_q});

  always_comb begin
    if (nr_a > A_MAX)      nr_s = A_MAX;
    else if (nr_a < A_MIN) nr_s = A_MIN;
    else                   nr_s = nr_a;
    if (ni_a > A_MAX)      ni_s = A_MAX;
    else if (ni_a < A_MIN) ni_s = A_MIN;
    else                   ni_s = ni_a;
  end

  assign mag    = {2'b00, rr_q[PW-2:0]} + {2'b00, ii_q[PW-2:0]};
  assign pass   = !pend_q || (mag < LIMIT);
  assign more   = pass && (cnt_q != cfg_i.max_iter);
  assign rng_ok = (nr_s < FOUR) && (nr_s > NEG_FOUR) && (ni_s < FOUR) && (ni_s > NEG_FOUR);
  assign go_on  = more && rng_ok;

  assign status_o.finish = !go_on;
  assign pixel_value_o   = level_q;
  assign done_o          = done_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      px_q <= MW'(xi_c) * MW'(cfg_i.pixel_step);
      py_q <= MW'(yi_c) * MW'(cfg_i.pixel_step);
    end
    if (cmd_i.coord) begin
      cr_q <= cr_d;
      ci_q <= ci_d;
    end
    if (cmd_i.mul) begin
      rr_q <= zr_q * zr_q;
      ii_q <= zi_q * zi_q;
      ri_q <= zr_q * zi_q;
    end
    if (cmd_i.load) begin
      zr_q <= '0;
      zi_q <= '0;
    end else if (cmd_i.step && go_on) begin
      zr_q <= nr_s[ZW-1:0];
      zi_q <= ni_s[ZW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      pend_q  <= 1'b0;
      level_q <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= cmd_i.step && !go_on;
      if (cmd_i.load) begin
        cnt_q   <= '0;
        pend_q  <= 1'b0;
        level_q <= '0;
      end else if (cmd_i.step) begin
        if (pend_q && pass) begin
          level_q <= LEVEL_TOP - (cnt_q - ITER_W'(1));
        end
        if (go_on) begin
          cnt_q  <= cnt_q + ITER_W'(1);
          pend_q <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/mandelbrot_escape_time_pixel_top.sv =====
// Escape-time evaluator for one pixel of a Mandelbrot image.
// Input: pulse start_i with x_index_i / y_index_i while busy_o is low; the
// indices are taken on that edge and busy_o rises on the next cycle.
// Output: done_o is high for exactly one cycle with pixel_value_o valid; the
// receiver cannot stall and must take the transfer in that cycle.
// Configuration: cfg_valid_i / cfg_ready_o with cfg_index_i and cfg_data_i,
// index 0 max_iterations, 1 pixel_step, 2 x_origin, 3 y_origin. Write only
// while busy_o is low; cfg_ready_o is always high.
// Sequence: the start edge scales the indices by pixel_step and the coordinate
// state adds the origin to give the point c; then each step of z = z*z + c
// runs a multiply state on the three-multiplier square unit and a step state
// on the add, saturate and escape-test stage. At most max_iterations new values
// of z are kept, and done_o is registered from the last escape test.
// A new start is taken in the cycle done_o is high.
// Reset: asynchronous, active low; drops any pixel in flight, returns to
// idle and loads the default view (-2.0 - 1.5i, step 10066, 255 steps).
module mandelbrot_escape_time_pixel_top #(
  parameter int unsigned MAX_DIM     = mbet_pkg::MAX_DIM_DEF,
  parameter int unsigned COORD_WIDTH = mbet_pkg::COORD_WIDTH_DEF,
  parameter int unsigned FRAC_BITS   = mbet_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [$clog2(MAX_DIM)-1:0]        x_index_i,
  input  logic [$clog2(MAX_DIM)-1:0]        y_index_i,
  output logic                              done_o,
  output logic [mbet_pkg::PIXEL_W-1:0]      pixel_value_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [mbet_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [mbet_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import mbet_pkg::*;

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  mbet_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  mbet_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .busy_o   (busy_o),
    .cmd_o    (cmd),
    .status_i (status)
  );

  mbet_dp #(
    .MAX_DIM     (MAX_DIM),
    .COORD_WIDTH (COORD_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .cfg_i         (cfg),
    .x_index_i     (x_index_i),
    .y_index_i     (y_index_i),
    .status_o      (status),
    .pixel_value_o (pixel_value_o),
    .done_o        (done_o)
  );

endmodule

// ===== rtl/mbet_chk.sv =====
module mbet_chk (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic done_o
);

  // hold done only as a single idle-cycle strobe
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o) else $error("done while busy");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done longer than one cycle");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o) else $error("start transfer not taken");

  a_end_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> done_o) else $error("pixel finished without result");

endmodule

bind mandelbrot_escape_time_pixel_top mbet_chk u_mbet_chk (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy_o  (busy_o),
  .done_o  (done_o)
);
